[hw/rtl/wcct_pkg.sv]
`default_nettype none
package wcct_pkg;

  localparam int unsigned DEF_NUM_WARPS     = 64;
  localparam int unsigned DEF_FRACTION_BITS = 8;

  localparam int unsigned WARP_W     = 6;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CRIT_W     = 48;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CRIT_W-1:0] CRIT_MAX = {1'b0, {(CRIT_W-1){1'b1}}};
  localparam logic [CRIT_W-1:0] CRIT_MIN = {1'b1, {(CRIT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ENTER    = 2'd0,
    OP_ISSUE    = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_CALC     = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_USE_AVG   = 1'b0,
    CFG_ADD_STALL = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_OUT,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] stall;
    logic [WORD_W-1:0] last;
    logic [WORD_W-1:0] enter;
    logic [WORD_W-1:0] cnt;
  } entry_t;

endpackage
`default_nettype wire

[hw/rtl/wcct_ram.sv]
`default_nettype none
module wcct_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/wcct_div.sv]
`default_nettype none
module wcct_div #(
  parameter int unsigned DIVIDEND_W = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIVIDEND_W-1:0]         dividend_i,
  input  logic [wcct_pkg::WORD_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [DIVIDEND_W-1:0]         quotient_o
);
  import wcct_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [WORD_W-1:0]     rem_q;
  logic [WORD_W-1:0]     dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [WORD_W:0] shifted;
  logic [WORD_W:0] diff;
  logic            ge;
  logic [WORD_W-1:0] rem_step;

  always_comb begin
    shifted  = {rem_q, quo_q[DIVIDEND_W-1]};
    diff     = shifted - {1'b0, dvs_q};
    ge       = (shifted >= {1'b0, dvs_q});
    rem_step = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= rem_step;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[hw/rtl/warp_criticality_counter_table_unit.sv]
`default_nettype none
// Per-warp criticality table. Events enter on the s_ stream (event kind in
// tuser) and are handled one at a time; s_tready is high only while the unit
// waits for an event. Enter, complete and issue events read, update and write
// back the entry; an issue event with a target runs the divider first. A
// calculate event runs the divider and then the multiplier with the measured
// cycles per instruction, only the multiplier with a cycles per instruction
// of one and neither when no instruction has completed yet; it then waits
// while the output register is full. W = 32 + FRACTION_BITS is the width of
// the bit-serial divider that forms both the PC distance count and the
// cycles-per-instruction quotient. The product uses one 16x32 multiplier on
// ceil(W/16) chunks of 16 bits. Each calculate event returns one item on the
// m_ stream through an output register, so the next event is taken while a
// result waits. Criticality is signed with FRACTION_BITS fraction bits and
// saturates at 48 bits. Events for warps at or above NUM_WARPS are dropped.
module warp_criticality_counter_table_unit #(
  parameter int unsigned NUM_WARPS     = wcct_pkg::DEF_NUM_WARPS,
  parameter int unsigned FRACTION_BITS = wcct_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wcct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wcct_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // warp[5:0] cycle[37:6] inst_count[53:38] target_valid[54]
  // target_pc[86:55] current_pc[118:87] inst_size[123:119]
  input  logic [wcct_pkg::IN_DATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [wcct_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // warp_out[5:0] criticality[53:6] saturated[54]
  output logic [wcct_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import wcct_pkg::*;

  localparam int unsigned DEPTH   = (NUM_WARPS < 64) ? NUM_WARPS : 64;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DIV_W   = WORD_W + FRACTION_BITS;
  localparam int unsigned MUL_CH  = (DIV_W + 15) / 16;
  localparam int unsigned MUL_W   = MUL_CH * 16;
  localparam int unsigned PROD_W  = MUL_W + WORD_W;
  localparam int unsigned MCNT_W  = $clog2(MUL_CH + 1);
  localparam int unsigned SUM_W   = 53;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(CRIT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

  state_e state_q, state_d;

  op_e               op_q;
  logic [WARP_W-1:0] warp_q;
  logic [WORD_W-1:0] cyc_q;
  logic [15:0]       ninst_q;
  logic              tv_q;
  logic [WORD_W-1:0] tpc_q;
  logic [WORD_W-1:0] cpc_q;
  logic [4:0]        isize_q;

  logic use_avg_q, add_stall_q;

  entry_t ent_q, ent_d;
  entry_t ram_rdata;
  logic   ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [DEPTH-1:0] vld_q;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [WORD_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  logic [MUL_W-1:0]  cpi_sh_q, cpi_sh_d;
  logic [MCNT_W-1:0] mul_cnt_q, mul_cnt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [47:0]       mul_part;
  logic [WORD_W-1:0] mag;

  logic [CRIT_W-1:0] res_crit_q, res_crit_d;
  logic              res_sat_q, res_sat_d;
  logic              out_load;

  logic              out_vld_q;
  logic [WARP_W-1:0] out_warp_q;
  logic [CRIT_W-1:0] out_crit_q;
  logic              out_sat_q;

  logic              warp_in_range;
  logic              backward;
  logic [WORD_W-1:0] pc_dist, pc_adj, div_q32;
  logic [WORD_W-1:0] stall_new;
  logic [WORD_W:0]   stall_sum;
  logic [WORD_W-1:0] isize_eff;

  logic signed [SUM_W-1:0] prod_s, sum_v;
  logic [SUM_W-1:0]        stall_ext;
  logic                    prod_big;

  assign warp_in_range = (32'(s_tdata[5:0]) < NUM_WARPS);
  assign ram_addr      = warp_q[AW-1:0];

  always_comb begin
    backward  = (tpc_q < cpc_q);
    pc_dist   = backward ? (cpc_q - tpc_q) : (tpc_q - cpc_q);
    div_q32   = div_quo[WORD_W-1:0];
    pc_adj    = (backward ? div_q32 : (~div_q32 + 32'd1)) + 32'd1;
    isize_eff = (isize_q == 5'd0) ? 32'd1 : 32'(isize_q);
    stall_sum = {1'b0, ent_q.stall} + {1'b0, cyc_q - ent_q.last};
    if ((ent_q.last != '0) && (cyc_q > ent_q.last)) begin
      stall_new = stall_sum[WORD_W] ? '1 : stall_sum[WORD_W-1:0];
    end else begin
      stall_new = ent_q.stall;
    end
    mag       = ent_q.rem[WORD_W-1] ? (~ent_q.rem + 32'd1) : ent_q.rem;
    mul_part  = 48'(cpi_sh_q[MUL_W-1 -: 16]) * 48'(mag);
    prod_big  = (prod_q > (PROD_W'(1) << 50));
    prod_s    = $signed({2'b00, prod_q[50:0]});
    stall_ext = SUM_W'(ent_q.stall) << FRACTION_BITS;
    sum_v     = ent_q.rem[WORD_W-1] ? -prod_s : prod_s;
    if (add_stall_q) begin
      sum_v = sum_v + $signed(stall_ext);
    end
  end

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    cpi_sh_d     = cpi_sh_q;
    mul_cnt_d    = mul_cnt_q;
    prod_d       = prod_q;
    res_crit_d   = res_crit_q;
    res_sat_d    = res_sat_q;
    out_load     = 1'b0;
    s_tready     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && warp_in_range) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        ent_d   = vld_q[ram_addr] ? ram_rdata : '0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op_q)
          OP_ENTER: begin
            ent_d.rem   = 32'(ninst_q);
            ent_d.enter = cyc_q;
            state_d     = ST_WRITE;
          end
          OP_ISSUE: begin
            ent_d.stall = stall_new;
            ent_d.last  = cyc_q;
            if (tv_q) begin
              div_start    = 1'b1;
              div_dividend = DIV_W'(pc_dist);
              div_divisor  = isize_eff;
              state_d      = ST_DIV;
            end else begin
              state_d = ST_WRITE;
            end
          end
          OP_COMPLETE: begin
            if (ent_q.cnt != '1) begin
              ent_d.cnt = ent_q.cnt + 32'd1;
            end
            ent_d.rem = ent_q.rem - 32'd1;
            state_d   = ST_WRITE;
          end
          OP_CALC: begin
            if (use_avg_q) begin
              if (ent_q.cnt == '0) begin
                res_crit_d = CRIT_MAX;
                res_sat_d  = 1'b1;
                state_d    = ST_OUT;
              end else begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(cyc_q - ent_q.enter) << FRACTION_BITS;
                div_divisor  = ent_q.cnt;
                state_d      = ST_DIV;
              end
            end else begin
              cpi_sh_d  = MUL_W'(1) << FRACTION_BITS;
              prod_d    = '0;
              mul_cnt_d = MCNT_W'(MUL_CH);
              state_d   = ST_MUL;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          if (op_q == OP_CALC) begin
            cpi_sh_d  = MUL_W'(div_quo);
            prod_d    = '0;
            mul_cnt_d = MCNT_W'(MUL_CH);
            state_d   = ST_MUL;
          end else begin
            ent_d.rem = ent_q.rem + pc_adj;
            state_d   = ST_WRITE;
          end
        end
      end
      ST_MUL: begin
        prod_d    = (prod_q << 16) + PROD_W'(mul_part);
        cpi_sh_d  = cpi_sh_q << 16;
        mul_cnt_d = mul_cnt_q - MCNT_W'(1);
        if (mul_cnt_q == MCNT_W'(1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (prod_big) begin
          res_sat_d  = 1'b1;
          res_crit_d = ent_q.rem[WORD_W-1] ? CRIT_MIN : CRIT_MAX;
        end else if (sum_v > SUM_MAX) begin
          res_sat_d  = 1'b1;
          res_crit_d = CRIT_MAX;
        end else if (sum_v < SUM_MIN) begin
          res_sat_d  = 1'b1;
          res_crit_d = CRIT_MIN;
        end else begin
          res_sat_d  = 1'b0;
          res_crit_d = sum_v[CRIT_W-1:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_q || m_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      use_avg_q   <= 1'b0;
      add_stall_q <= 1'b0;
      vld_q       <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_USE_AVG:   use_avg_q   <= cfg_wdata_i[0];
          CFG_ADD_STALL: add_stall_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (ram_we) begin
        vld_q[ram_addr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      op_q    <= op_e'(s_tuser[1:0]);
      warp_q  <= s_tdata[5:0];
      cyc_q   <= s_tdata[37:6];
      ninst_q <= s_tdata[53:38];
      tv_q    <= s_tdata[54];
      tpc_q   <= s_tdata[86:55];
      cpc_q   <= s_tdata[118:87];
      isize_q <= s_tdata[123:119];
    end
    ent_q      <= ent_d;
    cpi_sh_q   <= cpi_sh_d;
    mul_cnt_q  <= mul_cnt_d;
    prod_q     <= prod_d;
    res_crit_q <= res_crit_d;
    res_sat_q  <= res_sat_d;
    if (out_load) begin
      out_warp_q <= warp_q;
      out_crit_q <= res_crit_q;
      out_sat_q  <= res_sat_q;
    end
  end

  wcct_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ent_q),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  wcct_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {1'b0, out_sat_q, out_crit_q, out_warp_q};

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_no_write_on_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> op_q != OP_CALC)
    else $error("table written by a calculate event");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> $past(state_q) == ST_OUT)
    else $error("result appeared without passing the output state");

  a_drop_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready && !warp_in_range) |=> state_q == ST_IDLE)
    else $error("out-of-range warp was not dropped");

endmodule
`default_nettype wire
